// ===== rtl/core/tdt_pkg.sv =====
package tdt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int TASK_SLOTS    = 64;
   localparam int TASK_ID_WIDTH = 6;
   localparam int ADDR_WIDTH    = 64;
   localparam int PATTERN_WIDTH = 64;

   // bits of the mask that map to real task slots
   localparam logic [PATTERN_WIDTH-1:0] SLOT_MASK =
      ~({PATTERN_WIDTH{1'b1}} << TASK_SLOTS);

   typedef enum logic {
      OP_CHECK_UPDATE = 1'b0,
      OP_RELEASE      = 1'b1
   } tdt_op_type;

   typedef struct packed {
      tdt_op_type                op;
      logic [TASK_ID_WIDTH-1:0]  task_id;
      logic [ADDR_WIDTH-1:0]     dep_address;
      logic                      last_of_list;
   } tdt_req_type;

   typedef struct packed {
      logic [PATTERN_WIDTH-1:0]  dep_pattern;
      logic                      pattern_done;
      logic                      table_full;
   } tdt_rsp_type;

   // lookup broadcast from the input register to every entry
   typedef struct packed {
      logic                      check;
      logic                      release_dep;
      logic [TASK_ID_WIDTH-1:0]  task_id;
      logic [ADDR_WIDTH-1:0]     dep_address;
   } tdt_lookup_type;

endpackage

// ===== rtl/core/tdt_entry.sv =====
module tdt_entry (
   input  logic                                clock,
   input  logic                                reset,
   input  tdt_pkg::tdt_lookup_type             lookup,
   input  logic                                alloc_grant,
   output logic                                match,
   output logic                                free,
   output logic [tdt_pkg::PATTERN_WIDTH-1:0]   task_bit
);
   import tdt_pkg::*;

   logic                      valid_ff;
   logic                      valid_in;
   logic [ADDR_WIDTH-1:0]     address_ff;
   logic [ADDR_WIDTH-1:0]     address_in;
   logic [TASK_ID_WIDTH-1:0]  task_ff;
   logic [TASK_ID_WIDTH-1:0]  task_in;

   always_comb begin
      match    = valid_ff && (address_ff == lookup.dep_address);
      free     = !valid_ff;
      task_bit = match ? ((PATTERN_WIDTH'(1) << task_ff) & SLOT_MASK) : '0;
   end

   always_comb begin
      valid_in   = valid_ff;
      address_in = address_ff;
      task_in    = task_ff;
      if (lookup.check && match) begin
         // hand the entry over to the new task
         task_in = lookup.task_id;
      end else if (alloc_grant) begin
         valid_in   = 1'b1;
         address_in = lookup.dep_address;
         task_in    = lookup.task_id;
      end
      // drop only when the finishing task still owns the entry
      if (lookup.release_dep && match && (task_ff == lookup.task_id)) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      address_ff <= address_in;
      task_ff    <= task_in;
   end

endmodule

// ===== rtl/core/tdt_select.sv =====
module tdt_select (
   input  logic                                check,
   input  logic [tdt_pkg::TABLE_ENTRIES-1:0]   match_vec,
   input  logic [tdt_pkg::TABLE_ENTRIES-1:0]   free_vec,
   input  logic [tdt_pkg::PATTERN_WIDTH-1:0]   task_bits [tdt_pkg::TABLE_ENTRIES],
   output logic [tdt_pkg::TABLE_ENTRIES-1:0]   grant_vec,
   output logic                                table_full,
   output logic [tdt_pkg::PATTERN_WIDTH-1:0]   hit_pattern
);
   import tdt_pkg::*;

   logic                      hit;
   logic                      miss;
   logic [TABLE_ENTRIES-1:0]  lowest_free;

   always_comb begin
      hit  = |match_vec;
      miss = check && !hit;
      // isolate the lowest free entry
      lowest_free = free_vec & (~free_vec + TABLE_ENTRIES'(1));
      grant_vec   = miss ? lowest_free : '0;
      table_full  = miss && !(|free_vec);
   end

   // at most one entry matches, so an OR selects its task bit
   always_comb begin
      hit_pattern = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit_pattern = hit_pattern | task_bits[i];
      end
   end

endmodule

// ===== rtl/core/task_dependence_tracker_top.sv =====
// Last-writer table for task dependences. One transaction is accepted in
// every cycle (busy stays low) and its result appears on rsp_item with
// rsp_strobe from the result register: the input register captures the
// transaction on acceptance, and one pass through the parallel address
// compare of all table entries then loads the result register.
// The receiver cannot stall, so every result must be taken in the cycle its
// strobe is high. The table is empty right after reset; the entry valid bits
// clear at once, so no clearing pass is needed.
module task_dependence_tracker_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tdt_pkg::tdt_req_type   req_item,
   output logic                   rsp_strobe,
   output tdt_pkg::tdt_rsp_type   rsp_item
);
   import tdt_pkg::*;

   logic                      req_valid_ff;
   logic                      req_valid_in;
   tdt_req_type               req_data_ff;
   logic                      rsp_strobe_ff;
   logic                      rsp_strobe_in;
   tdt_rsp_type               rsp_item_ff;
   tdt_rsp_type               rsp_item_in;
   logic [PATTERN_WIDTH-1:0]  acc_ff;
   logic [PATTERN_WIDTH-1:0]  acc_in;

   tdt_lookup_type            lookup;
   logic [TABLE_ENTRIES-1:0]  match_vec;
   logic [TABLE_ENTRIES-1:0]  free_vec;
   logic [TABLE_ENTRIES-1:0]  grant_vec;
   logic [PATTERN_WIDTH-1:0]  task_bits [TABLE_ENTRIES];
   logic                      table_full;
   logic [PATTERN_WIDTH-1:0]  hit_pattern;
   logic [PATTERN_WIDTH-1:0]  pattern_sum;
   logic                      accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_comb begin
      lookup.check       = req_valid_ff && (req_data_ff.op == OP_CHECK_UPDATE);
      lookup.release_dep = req_valid_ff && (req_data_ff.op == OP_RELEASE);
      lookup.task_id     = req_data_ff.task_id;
      lookup.dep_address = req_data_ff.dep_address;
   end

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_entry
      tdt_entry u_entry (
         .clock       (clock),
         .reset       (reset),
         .lookup      (lookup),
         .alloc_grant (grant_vec[g]),
         .match       (match_vec[g]),
         .free        (free_vec[g]),
         .task_bit    (task_bits[g])
      );
   end

   tdt_select u_select (
      .check       (lookup.check),
      .match_vec   (match_vec),
      .free_vec    (free_vec),
      .task_bits   (task_bits),
      .grant_vec   (grant_vec),
      .table_full  (table_full),
      .hit_pattern (hit_pattern)
   );

   always_comb begin
      req_valid_in  = accept;
      rsp_strobe_in = req_valid_ff;
      pattern_sum   = acc_ff | hit_pattern;
      rsp_item_in   = '0;
      acc_in        = acc_ff;
      if (lookup.check) begin
         rsp_item_in.dep_pattern  = pattern_sum;
         rsp_item_in.pattern_done = req_data_ff.last_of_list;
         rsp_item_in.table_full   = table_full;
         // clear the mask once the list ends
         acc_in = req_data_ff.last_of_list ? '0 : pattern_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         acc_ff        <= '0;
      end else begin
         req_valid_ff  <= req_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         acc_ff        <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_data_ff <= req_item;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule
